FILE: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// Used by the front, queue, back and top modules; no dependencies.
package i2cm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DELAY_WIDTH_DEF = 16;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd250;
  localparam logic [7:0] ADDR_READ_BIT = 8'h80;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_BEGIN = 2'd1;
  localparam logic [1:0] REQ_SUPPLY = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_BEGIN,
    OP_SUPPLY,
    OP_NONE
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_S0, PH_S1, PH_S2, PH_S3,
    PH_W0, PH_W1, PH_W2,
    PH_A0, PH_A1, PH_A2, PH_A3, PH_A4,
    PH_R0, PH_R1, PH_R2, PH_R3,
    PH_K0, PH_K1, PH_K2, PH_K3, PH_K4,
    PH_P0, PH_P1, PH_P2,
    PH_HOLD
  } phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        line_sda;
    logic [6:0]  target_addr;
    logic        read_not_write;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       wants_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic       status;
    logic       rejected;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic        line_sda;
    logic [6:0]  target_addr;
    logic        read_not_write;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
  } cmd_t;

endpackage

FILE: sv/i2cm_front.sv
// Front end: takes requests off the input channel and classifies them.
// Depends on i2cm_pkg; feeds i2cm_queue.
module i2cm_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  i2cm_pkg::in_t  in_data,
  input  logic           q_full,
  output logic           push,
  output i2cm_pkg::cmd_t cmd
);
  import i2cm_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.line_sda       = in_data.line_sda;
    cmd.target_addr    = in_data.target_addr;
    cmd.read_not_write = in_data.read_not_write;
    cmd.byte_count     = in_data.byte_count;
    cmd.data_byte      = in_data.data_byte;
    case (in_data.req_type)
      REQ_TICK:   cmd.op = OP_TICK;
      REQ_BEGIN:  cmd.op = OP_BEGIN;
      REQ_SUPPLY: cmd.op = OP_SUPPLY;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: sv/i2cm_queue.sv
// Short request queue between the front end and the bit engine.
// Depends on i2cm_pkg for the command type and depth.
module i2cm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  i2cm_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output i2cm_pkg::cmd_t pop_data
);
  import i2cm_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full      = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/i2cm_back.sv
// Back end: I2C bit sequencer, holding register and result register.
// Depends on i2cm_pkg; consumes commands from i2cm_queue.
module i2cm_back #(
  parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEF,
  parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic [15:0]    cfg_data,
  input  logic           q_valid,
  input  i2cm_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output i2cm_pkg::out_t out_data
);
  import i2cm_pkg::*;

  localparam int CMP_W = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;

  logic [15:0]            phase_ticks_r;
  phase_t                 phase_r, phase_nxt;
  logic [DELAY_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [3:0]             bit_index_r, bit_index_nxt;
  logic [7:0]             shift_reg_r, shift_reg_nxt;
  logic [COUNT_WIDTH-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]             hold_byte_r, hold_byte_nxt;
  logic                   hold_full_r, hold_full_nxt;
  logic                   is_read_r, is_read_nxt;
  logic                   scl_low_r, scl_low_nxt;
  logic                   sda_low_r, sda_low_nxt;
  logic                   nack_seen_r, nack_seen_nxt;

  logic                   ev_read_valid, ev_done, ev_status, ev_rejected;
  logic                   out_valid_r;
  out_t                   out_data_r, res;
  logic                   fire;

  assign fire      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state: one request per call of the step logic.
  always_comb begin
    logic                   go_wb;
    logic                   go_rb;
    logic                   do_enter;
    phase_t                 tgt;
    logic [31:0]            cnt_ext;
    logic [DELAY_WIDTH-1:0] tick_inc;
    go_wb          = 1'b0;
    go_rb          = 1'b0;
    do_enter       = 1'b0;
    tgt            = phase_r;
    cnt_ext        = 32'(q_data.byte_count);
    tick_inc       = tick_count_r + DELAY_WIDTH'(1);
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_reg_nxt  = shift_reg_r;
    bytes_left_nxt = bytes_left_r;
    hold_byte_nxt  = hold_byte_r;
    hold_full_nxt  = hold_full_r;
    is_read_nxt    = is_read_r;
    scl_low_nxt    = scl_low_r;
    sda_low_nxt    = sda_low_r;
    nack_seen_nxt  = nack_seen_r;
    ev_read_valid  = 1'b0;
    ev_done        = 1'b0;
    ev_status      = 1'b0;
    ev_rejected    = 1'b0;

    case (q_data.op)
      OP_TICK: begin
        if (phase_r == PH_HOLD) begin
          go_wb = hold_full_r;
        end else if (phase_r != PH_IDLE) begin
          tick_count_nxt = tick_inc;
          if (CMP_W'(tick_inc) >= CMP_W'(phase_ticks_r)) begin
            do_enter = 1'b1;
            case (phase_r)
              PH_S3: begin
                bit_index_nxt = '0;
                tgt = PH_W0;
              end
              PH_W2: begin
                shift_reg_nxt = {shift_reg_r[6:0], 1'b0};
                bit_index_nxt = bit_index_r + 1'b1;
                tgt = bit_index_nxt[3] ? PH_A0 : PH_W0;
              end
              PH_A4: begin
                if (nack_seen_r) begin
                  tgt = PH_P0;
                end else begin
                  do_enter = 1'b0;
                  go_rb = is_read_r;
                  go_wb = !is_read_r;
                end
              end
              PH_R3: begin
                bit_index_nxt = bit_index_r + 1'b1;
                tgt = bit_index_nxt[3] ? PH_K0 : PH_R0;
              end
              PH_K4: begin
                do_enter = 1'b0;
                go_rb = 1'b1;
              end
              PH_P2: begin
                do_enter       = 1'b0;
                ev_done        = 1'b1;
                ev_status      = nack_seen_r;
                nack_seen_nxt  = 1'b0;
                hold_full_nxt  = 1'b0;
                phase_nxt      = PH_IDLE;
                tick_count_nxt = '0;
              end
              default: begin
                tgt = phase_t'(phase_r + 5'd1);
              end
            endcase
          end
        end
      end
      OP_BEGIN: begin
        if (phase_r != PH_IDLE) begin
          ev_rejected = 1'b1;
        end else begin
          is_read_nxt    = q_data.read_not_write;
          shift_reg_nxt  = {q_data.target_addr, q_data.read_not_write};
          bytes_left_nxt = cnt_ext[COUNT_WIDTH-1:0];
          bit_index_nxt  = '0;
          nack_seen_nxt  = 1'b0;
          if (q_data.read_not_write) begin
            hold_full_nxt = 1'b0;
          end
          tgt      = PH_S0;
          do_enter = 1'b1;
        end
      end
      OP_SUPPLY: begin
        if (hold_full_r) begin
          ev_rejected = 1'b1;
        end else begin
          hold_byte_nxt = q_data.data_byte;
          hold_full_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Pick the next byte, or go to stop when none are left, once an ACK slot or the holding wait is over.
    if (go_wb) begin
      do_enter = 1'b1;
      if (bytes_left_r == '0) begin
        tgt = PH_P0;
      end else if (hold_full_r) begin
        shift_reg_nxt  = hold_byte_r;
        hold_full_nxt  = 1'b0;
        bytes_left_nxt = bytes_left_r - 1'b1;
        bit_index_nxt  = '0;
        tgt = PH_W0;
      end else begin
        tgt = PH_HOLD;
      end
    end
    if (go_rb) begin
      do_enter = 1'b1;
      if (bytes_left_r == '0) begin
        tgt = PH_P0;
      end else begin
        bytes_left_nxt = bytes_left_r - 1'b1;
        bit_index_nxt  = '0;
        shift_reg_nxt  = '0;
        tgt = PH_R0;
      end
    end

    // Pin and sample actions on entry to a phase.
    if (do_enter) begin
      phase_nxt      = tgt;
      tick_count_nxt = '0;
      case (tgt)
        PH_S0: sda_low_nxt = 1'b0;
        PH_S1: scl_low_nxt = 1'b0;
        PH_S2: sda_low_nxt = 1'b1;
        PH_S3: scl_low_nxt = 1'b1;
        PH_W0: scl_low_nxt = 1'b1;
        PH_W1: sda_low_nxt = ((shift_reg_nxt & ADDR_READ_BIT) == 8'h00);
        PH_W2: scl_low_nxt = 1'b0;
        PH_A0: scl_low_nxt = 1'b1;
        PH_A1: sda_low_nxt = 1'b0;
        PH_A2: scl_low_nxt = 1'b0;
        PH_A3: nack_seen_nxt = q_data.line_sda;
        PH_A4: scl_low_nxt = 1'b1;
        PH_R0: begin
          scl_low_nxt = 1'b1;
          sda_low_nxt = 1'b0;
        end
        PH_R2: scl_low_nxt = 1'b0;
        PH_R3: begin
          shift_reg_nxt = {shift_reg_nxt[6:0], q_data.line_sda};
          ev_read_valid = (bit_index_nxt == 4'd7);
        end
        PH_K0: scl_low_nxt = 1'b1;
        PH_K1: sda_low_nxt = (bytes_left_nxt != '0);
        PH_K2: scl_low_nxt = 1'b0;
        PH_K4: scl_low_nxt = 1'b1;
        PH_P0: sda_low_nxt = 1'b1;
        PH_P1: scl_low_nxt = 1'b0;
        PH_P2: sda_low_nxt = 1'b0;
        default: begin
        end
      endcase
    end
  end

  // Result of the request, seen after it is applied.
  always_comb begin
    res.scl_drive_low = scl_low_nxt;
    res.sda_drive_low = sda_low_nxt;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.wants_byte    = (phase_nxt != PH_IDLE) && !is_read_nxt && !hold_full_nxt &&
                        (bytes_left_nxt != '0);
    res.read_valid    = ev_read_valid;
    res.read_byte     = ev_read_valid ? shift_reg_nxt : 8'h00;
    res.done_res      = ev_done;
    res.status        = ev_status;
    res.rejected      = ev_rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_valid) begin
      phase_ticks_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      bit_index_r  <= '0;
      shift_reg_r  <= '0;
      bytes_left_r <= '0;
      hold_byte_r  <= '0;
      hold_full_r  <= 1'b0;
      is_read_r    <= 1'b0;
      scl_low_r    <= 1'b0;
      sda_low_r    <= 1'b0;
      nack_seen_r  <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_reg_r  <= shift_reg_nxt;
      bytes_left_r <= bytes_left_nxt;
      hold_byte_r  <= hold_byte_nxt;
      hold_full_r  <= hold_full_nxt;
      is_read_r    <= is_read_nxt;
      scl_low_r    <= scl_low_nxt;
      sda_low_r    <= sda_low_nxt;
      nack_seen_r  <= nack_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: sv/i2c_master_bit_engine_unit.sv
// Top level of the I2C master bit engine: front end, request queue, bit engine.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
//
//   channel | ports                          | direction
//   in      | in_valid, in_ready, in_data    | request in (in_t)
//   out     | out_valid, out_ready, out_data | one result per request (out_t)
//   cfg     | cfg_valid, cfg_ready, cfg_data | phase_ticks write, always ready
//
// One request per clock sustained while out_ready keeps up; a result is registered
// when the engine takes its request from the queue head, via the combinational step.
// A two-entry queue decouples intake from the result register, so requests
// keep flowing while a result waits; in_ready drops only when the queue fills.
// Synchronous active-low reset returns to idle with phase_ticks at 250.
module i2c_master_bit_engine_unit #(
  parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEF,
  parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  i2cm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output i2cm_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);
  import i2cm_pkg::*;

  cmd_t front_cmd, q_head;
  logic push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_head)
  );

  i2cm_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");

  a_read_in_txn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> out_data.busy_res && !out_data.wants_byte)
    else $error("read byte outside a read transaction");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_result_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("request taken without a result");
`endif

endmodule
